@@ hdl/uer_pkg.sv @@
// Shared constants, register map and controller/datapath interface types.
package uer_pkg;

  localparam int SAMPLE_COUNT = 5;

  localparam int TRIG_W  = 10;
  localparam int PRE_W   = 16;
  localparam int UNITS_W = 16;
  localparam int SPEED_W = 10;
  localparam int SUM_W   = 19;
  localparam int IDX_W   = 3;
  localparam int DIST_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [IDX_W-1:0] SMP_CNT = IDX_W'(SAMPLE_COUNT);

  // Reciprocal for the burst average: floor(x / N) = (x * RECIP) >> DIV_SHIFT
  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'(1) << DIV_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / RECIP_W'(SAMPLE_COUNT);

  localparam int DPROD_W = SUM_W + RECIP_W;
  localparam int P1_W    = SUM_W + PRE_W;
  localparam int P2_W    = P1_W + SPEED_W;

  localparam logic [TRIG_W-1:0]  TRIG_RST  = 10'd40;
  localparam logic [PRE_W-1:0]   PRE_RST   = 16'd500;
  localparam logic [UNITS_W-1:0] WRAP_RST  = 16'd1999;
  localparam logic [SPEED_W-1:0] SPEED_RST = 10'd340;

  typedef enum logic [1:0] {
    REG_TRIG_TICKS = 2'd0,
    REG_PRESCALE   = 2'd1,
    REG_WRAP       = 2'd2,
    REG_SPEED      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trig_ticks;
    logic [PRE_W-1:0]   count_prescale;
    logic [UNITS_W-1:0] count_wrap;
    logic [SPEED_W-1:0] speed_mps;
  } cfg_t;

  typedef struct packed {
    logic start_burst;
    logic begin_trig;
    logic trig_inc;
    logic echo_first;
    logic count_tick;
    logic close_sample;
    logic div_en;
    logic mulp_en;
    logic muls_en;
    logic sat_en;
  } cmd_t;

  typedef struct packed {
    logic trig_expire;
    logic sample_last;
  } status_t;

endpackage

@@ hdl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger top level: config registers, controller and datapath.
// Throughput: one tick beat per cycle unless the output stalls; after the beat
// that closes the last sample of a burst, input waits for the reciprocal divide, two multiply stages and saturation.
// Each accepted tick gives a registered result beat in the next cycle; the done beat is loaded in the SAT state.
// Reset (rst_n low, synchronous): idle, counters and distance cleared,
// registers at trig 40, prescale 500, wrap 1999, speed 340.
module ultrasonic_echo_ranger (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_start_req,
  input  logic                       in_echo,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_trig,
  output logic                       out_busy_res,
  output logic                       out_done_res,
  output logic [uer_pkg::DIST_W-1:0] out_distance_um,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  uer_pkg::cfg_t    cfg;
  uer_pkg::cmd_t    cmd;
  uer_pkg::status_t status;

  uer_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uer_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .distance_um (out_distance_um)
  );

  uer_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .in_echo      (in_echo),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trig     (out_trig),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .status       (status),
    .cmd          (cmd)
  );

endmodule

@@ hdl/uer_regs.sv @@
// APB configuration register bank.
module uer_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [uer_pkg::DATA_W-1:0] pwdata,
  output logic [uer_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output uer_pkg::cfg_t              cfg
);

  uer_pkg::cfg_t    cfg_r;
  uer_pkg::cfg_t    cfg_nxt;
  uer_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = uer_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        uer_pkg::REG_TRIG_TICKS: cfg_nxt.trig_ticks     = pwdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_PRESCALE:   cfg_nxt.count_prescale = pwdata[uer_pkg::PRE_W-1:0];
        uer_pkg::REG_WRAP:       cfg_nxt.count_wrap     = pwdata[uer_pkg::UNITS_W-1:0];
        uer_pkg::REG_SPEED:      cfg_nxt.speed_mps      = pwdata[uer_pkg::SPEED_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      uer_pkg::REG_TRIG_TICKS: prdata = uer_pkg::DATA_W'(cfg_r.trig_ticks);
      uer_pkg::REG_PRESCALE:   prdata = uer_pkg::DATA_W'(cfg_r.count_prescale);
      uer_pkg::REG_WRAP:       prdata = uer_pkg::DATA_W'(cfg_r.count_wrap);
      uer_pkg::REG_SPEED:      prdata = uer_pkg::DATA_W'(cfg_r.speed_mps);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_ticks     <= uer_pkg::TRIG_RST;
      cfg_r.count_prescale <= uer_pkg::PRE_RST;
      cfg_r.count_wrap     <= uer_pkg::WRAP_RST;
      cfg_r.speed_mps      <= uer_pkg::SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/uer_datapath.sv @@
// Datapath: trigger timer, echo unit counter, burst sum and distance arithmetic.
module uer_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  uer_pkg::cfg_t              cfg,
  input  uer_pkg::cmd_t              cmd,
  output uer_pkg::status_t           status,
  output logic [uer_pkg::DIST_W-1:0] distance_um
);

  logic [uer_pkg::TRIG_W-1:0]  trig_timer_r, trig_timer_nxt, trig_inc;
  logic [uer_pkg::PRE_W-1:0]   prescale_r, prescale_nxt, pre_base, pre_inc;
  logic [uer_pkg::UNITS_W-1:0] units_r, units_nxt, units_base;
  logic [uer_pkg::SUM_W-1:0]   width_sum_r, width_sum_nxt;
  logic [uer_pkg::IDX_W-1:0]   sample_idx_r, sample_idx_nxt, idx_inc;
  logic [uer_pkg::DIST_W-1:0]  last_dist_r, last_dist_nxt;
  logic [uer_pkg::DPROD_W-1:0] dprod_r;
  logic [uer_pkg::P1_W-1:0]    p1_r;
  logic [uer_pkg::P2_W-1:0]    p2_r;
  logic [uer_pkg::SUM_W-1:0]   avg;

  assign trig_inc = trig_timer_r + uer_pkg::TRIG_W'(1);
  assign idx_inc  = sample_idx_r + uer_pkg::IDX_W'(1);

  assign status.trig_expire = (trig_inc >= cfg.trig_ticks) || (trig_inc == '0);
  assign status.sample_last = (idx_inc >= uer_pkg::SMP_CNT);

  assign pre_base   = cmd.echo_first ? '0 : prescale_r;
  assign units_base = cmd.echo_first ? '0 : units_r;
  assign pre_inc    = pre_base + uer_pkg::PRE_W'(1);

  assign avg = dprod_r[uer_pkg::DIV_SHIFT +: uer_pkg::SUM_W];

  assign distance_um = last_dist_r;

  always_comb begin
    trig_timer_nxt = trig_timer_r;
    prescale_nxt   = prescale_r;
    units_nxt      = units_r;
    width_sum_nxt  = width_sum_r;
    sample_idx_nxt = sample_idx_r;
    last_dist_nxt  = last_dist_r;

    if (cmd.start_burst) begin
      width_sum_nxt  = '0;
      sample_idx_nxt = '0;
    end
    if (cmd.trig_inc) begin
      trig_timer_nxt = trig_inc;
    end
    if (cmd.echo_first || cmd.count_tick) begin
      prescale_nxt = pre_inc;
      units_nxt    = units_base;
      if (pre_inc >= cfg.count_prescale) begin
        prescale_nxt = '0;
        if (units_base >= cfg.count_wrap) begin
          units_nxt = '0;
        end else begin
          units_nxt = units_base + uer_pkg::UNITS_W'(1);
        end
      end
    end
    if (cmd.close_sample) begin
      width_sum_nxt  = width_sum_r + uer_pkg::SUM_W'(units_r);
      sample_idx_nxt = idx_inc;
    end
    if (cmd.begin_trig) begin
      trig_timer_nxt = '0;
      prescale_nxt   = '0;
      units_nxt      = '0;
    end
    if (cmd.sat_en) begin
      if (|p2_r[uer_pkg::P2_W-1:uer_pkg::DIST_W+1]) begin
        last_dist_nxt = '1;
      end else begin
        last_dist_nxt = p2_r[uer_pkg::DIST_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_timer_r <= '0;
      prescale_r   <= '0;
      units_r      <= '0;
      width_sum_r  <= '0;
      sample_idx_r <= '0;
      last_dist_r  <= '0;
    end else begin
      trig_timer_r <= trig_timer_nxt;
      prescale_r   <= prescale_nxt;
      units_r      <= units_nxt;
      width_sum_r  <= width_sum_nxt;
      sample_idx_r <= sample_idx_nxt;
      last_dist_r  <= last_dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      dprod_r <= uer_pkg::DPROD_W'(width_sum_r) * uer_pkg::DPROD_W'(uer_pkg::RECIP);
    end
    if (cmd.mulp_en) begin
      p1_r <= uer_pkg::P1_W'(avg) * uer_pkg::P1_W'(cfg.count_prescale);
    end
    if (cmd.muls_en) begin
      p2_r <= uer_pkg::P2_W'(p1_r) * uer_pkg::P2_W'(cfg.speed_mps);
    end
  end

endmodule

@@ hdl/uer_ctrl.sv @@
// Controller: measurement phase sequencer, result sequencing and output beat register.
module uer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_start_req,
  input  logic             in_echo,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_trig,
  output logic             out_busy_res,
  output logic             out_done_res,
  input  uer_pkg::status_t status,
  output uer_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TRIG  = 8'b0000_0010,
    ST_WAIT  = 8'b0000_0100,
    ST_COUNT = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_MULP  = 8'b0010_0000,
    ST_MULS  = 8'b0100_0000,
    ST_SAT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_trig_r, out_trig_nxt;
  logic   out_busy_r, out_busy_nxt;
  logic   out_done_r, out_done_nxt;
  logic   accepting;
  logic   in_fire;
  logic   load;
  logic   done_v;

  assign accepting = (state_r == ST_IDLE) || (state_r == ST_TRIG) ||
                     (state_r == ST_WAIT) || (state_r == ST_COUNT);
  assign in_ready  = accepting && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  assign out_valid    = out_valid_r;
  assign out_trig     = out_trig_r;
  assign out_busy_res = out_busy_r;
  assign out_done_res = out_done_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    load      = 1'b0;
    done_v    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          if (in_start_req) begin
            cmd.start_burst = 1'b1;
            cmd.begin_trig  = 1'b1;
            state_nxt       = ST_TRIG;
          end
        end
      end
      ST_TRIG: begin
        if (in_fire) begin
          load         = 1'b1;
          cmd.trig_inc = 1'b1;
          if (status.trig_expire) begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (in_fire) begin
          load = 1'b1;
          if (in_echo) begin
            cmd.echo_first = 1'b1;
            state_nxt      = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (in_fire) begin
          if (in_echo) begin
            load           = 1'b1;
            cmd.count_tick = 1'b1;
          end else begin
            cmd.close_sample = 1'b1;
            if (status.sample_last) begin
              state_nxt = ST_DIV;
            end else begin
              load           = 1'b1;
              cmd.begin_trig = 1'b1;
              state_nxt      = ST_TRIG;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_MULP;
      end
      ST_MULP: begin
        cmd.mulp_en = 1'b1;
        state_nxt   = ST_MULS;
      end
      ST_MULS: begin
        cmd.muls_en = 1'b1;
        state_nxt   = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat_en = 1'b1;
        load       = 1'b1;
        done_v     = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_trig_nxt  = out_trig_r;
    out_busy_nxt  = out_busy_r;
    out_done_nxt  = out_done_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_trig_nxt  = (state_nxt == ST_TRIG);
      out_busy_nxt  = (state_nxt != ST_IDLE);
      out_done_nxt  = done_v;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_trig_r <= out_trig_nxt;
    out_busy_r <= out_busy_nxt;
    out_done_r <= out_done_nxt;
  end

  a_sat_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAT) |=> (out_valid_r && out_done_r && !out_busy_r))
    else $error("result beat missing after distance saturation step");

  a_no_accept_in_math: assert property (@(posedge clk) disable iff (!rst_n)
    !accepting |-> !in_ready)
    else $error("input accepted during distance computation");

  a_last_sample_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (state_r == ST_COUNT) && !in_echo && status.sample_last)
      |=> ((state_r == ST_DIV) && !out_valid_r))
    else $error("final sample did not enter averaging");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (!out_busy_r && !out_trig_r))
    else $error("done beat flagged busy or trigger");

endmodule

@@ tb/tb_ultrasonic_echo_ranger.sv @@
// Testbench for ultrasonic_echo_ranger: per-tick predicted results checked against DUT beats.
module tb_ultrasonic_echo_ranger;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {RG_IDLE, RG_TRIG, RG_WAIT, RG_COUNT} rg_phase_t;

  typedef struct packed {
    logic                       trig;
    logic                       busy;
    logic                       done;
    logic [uer_pkg::DIST_W-1:0] distance;
  } ranger_out_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_start_req = 1'b0;
  logic                       in_echo = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_trig;
  logic                       out_busy_res;
  logic                       out_done_res;
  logic [uer_pkg::DIST_W-1:0] out_distance_um;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [uer_pkg::ADDR_W-1:0] paddr = '0;
  logic [uer_pkg::DATA_W-1:0] pwdata = '0;
  logic [uer_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // predictor copy of registers and state
  logic [uer_pkg::TRIG_W-1:0]  trig_ticks_cfg = uer_pkg::TRIG_RST;
  logic [uer_pkg::PRE_W-1:0]   prescale_cfg = uer_pkg::PRE_RST;
  logic [uer_pkg::UNITS_W-1:0] wrap_cfg = uer_pkg::WRAP_RST;
  logic [uer_pkg::SPEED_W-1:0] speed_cfg = uer_pkg::SPEED_RST;
  rg_phase_t                   rg_phase = RG_IDLE;
  logic [uer_pkg::TRIG_W-1:0]  trig_timer = '0;
  logic [uer_pkg::PRE_W-1:0]   base_count = '0;
  logic [uer_pkg::UNITS_W-1:0] echo_units = '0;
  logic [uer_pkg::SUM_W-1:0]   width_total = '0;
  logic [uer_pkg::IDX_W-1:0]   samples_done = '0;
  logic [uer_pkg::DIST_W-1:0]  last_distance = '0;

  ranger_out_t pending_ranger_out[$];
  ranger_out_t want;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          ticks_sent = 0;
  bit          gaps_on = 1'b1;
  int          stall_request = 0;
  int          stall_left = 0;

  ultrasonic_echo_ranger uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .in_echo        (in_echo),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_trig       (out_trig),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_distance_um(out_distance_um),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** ultrasonic_echo_ranger: FAILED **");
      $finish;
    end
  end

  function automatic void count_base_tick();
    base_count = base_count + 1'b1;
    if (base_count >= prescale_cfg) begin
      base_count = '0;
      if (echo_units >= wrap_cfg) begin
        echo_units = '0;
      end else begin
        echo_units = echo_units + 1'b1;
      end
    end
  endfunction

  function automatic void arm_trigger();
    rg_phase   = RG_TRIG;
    trig_timer = '0;
    base_count = '0;
    echo_units = '0;
  endfunction

  function automatic ranger_out_t predict_ranger_tick(input logic start, input logic echo);
    logic        done;
    logic [63:0] avg;
    logic [63:0] scaled;
    ranger_out_t res;
    done = 1'b0;
    case (rg_phase)
      RG_IDLE: begin
        if (start) begin
          width_total  = '0;
          samples_done = '0;
          arm_trigger();
        end
      end
      RG_TRIG: begin
        trig_timer = trig_timer + 1'b1;
        if (trig_timer >= trig_ticks_cfg || trig_timer == '0) rg_phase = RG_WAIT;
      end
      RG_WAIT: begin
        if (echo) begin
          rg_phase   = RG_COUNT;
          base_count = '0;
          echo_units = '0;
          count_base_tick();
        end
      end
      RG_COUNT: begin
        if (echo) begin
          count_base_tick();
        end else begin
          width_total  = width_total + uer_pkg::SUM_W'(echo_units);
          samples_done = samples_done + 1'b1;
          if (samples_done >= uer_pkg::SMP_CNT) begin
            avg    = 64'(width_total) / 64'(uer_pkg::SAMPLE_COUNT);
            scaled = (avg * 64'(prescale_cfg) * 64'(speed_cfg)) >> 1;
            last_distance = (scaled > 64'hFFFF_FFFF) ? '1 : scaled[uer_pkg::DIST_W-1:0];
            rg_phase = RG_IDLE;
            done     = 1'b1;
          end else begin
            arm_trigger();
          end
        end
      end
      default: rg_phase = RG_IDLE;
    endcase
    res.trig     = (rg_phase == RG_TRIG);
    res.busy     = (rg_phase != RG_IDLE);
    res.done     = done;
    res.distance = last_distance;
    return res;
  endfunction

  // receiver: random stalls, or a counted hold-off on request
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_ranger_out.size() == 0) begin
        $error("result beat with no tick pending");
        fail_count++;
      end else begin
        want = pending_ranger_out.pop_front();
        if (out_trig !== want.trig) begin
          $error("trig: expected %0d, got %0d", want.trig, out_trig);
          fail_count++;
        end
        if (out_busy_res !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, out_busy_res);
          fail_count++;
        end
        if (out_done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, out_done_res);
          fail_count++;
        end
        if (out_distance_um !== want.distance) begin
          $error("distance_um: expected %0d, got %0d", want.distance, out_distance_um);
          fail_count++;
        end
      end
    end
  end

  task automatic send_tick(input logic start, input logic echo);
    if (gaps_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_echo      <= echo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_ranger_out.push_back(predict_ranger_tick(start, echo));
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_ranger_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input uer_pkg::reg_idx_t idx,
                           input logic [uer_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      uer_pkg::REG_TRIG_TICKS: trig_ticks_cfg = value[uer_pkg::TRIG_W-1:0];
      uer_pkg::REG_PRESCALE:   prescale_cfg = value[uer_pkg::PRE_W-1:0];
      uer_pkg::REG_WRAP:       wrap_cfg = value[uer_pkg::UNITS_W-1:0];
      uer_pkg::REG_SPEED:      speed_cfg = value[uer_pkg::SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int trig, input int prescale, input int wrap, input int speed);
    drain_results();
    write_reg(uer_pkg::REG_TRIG_TICKS, trig);
    write_reg(uer_pkg::REG_PRESCALE, prescale);
    write_reg(uer_pkg::REG_WRAP, wrap);
    write_reg(uer_pkg::REG_SPEED, speed);
  endtask

  // one well-formed burst from idle; start bits while busy are random
  task automatic run_burst(input int w_lo, input int w_hi, input int gap_hi);
    send_tick(1'b1, 1'($urandom_range(1)));
    repeat (uer_pkg::SAMPLE_COUNT) begin
      while (rg_phase == RG_TRIG) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      repeat ($urandom_range(gap_hi)) send_tick(1'($urandom_range(1)), 1'b0);
      repeat ($urandom_range(w_lo, w_hi)) send_tick(1'($urandom_range(1)), 1'b1);
      send_tick(1'($urandom_range(1)), 1'b0);
    end
  endtask

  task automatic settle_to_idle();
    while (rg_phase != RG_IDLE) send_tick(1'b0, rg_phase == RG_WAIT);
  endtask

  task automatic test_reset_config();
    gaps_on = 1'b0;
    run_burst(1, 4, 3);
    gaps_on = 1'b1;
  endtask

  task automatic test_trigger_width();
    configure(0, 1, 100, 340);
    run_burst(1, 3, 2);
    configure(1, 3, 1000, 343);
    run_burst(2, 4, 1);
    configure(17, 2, 1000, 1);
    run_burst(1, 5, 0);
  endtask

  task automatic test_counter_limits();
    configure(5, 0, 65535, 1023);
    run_burst(1, 16, 2);
    configure(5, 1, 0, 1023);
    run_burst(1, 16, 2);
    configure(5, 1, 3, 500);
    run_burst(3, 12, 2);
    configure(5, 65535, 65535, 1023);
    run_burst(1, 16, 2);
    configure(5, 3, 65535, 1023);
    gaps_on = 1'b0;
    run_burst(20, 40, 2);
    gaps_on = 1'b1;
    configure(5, 1, 65535, 0);
    run_burst(1, 16, 2);
  endtask

  // echo never rises: block must sit in wait; then finish the burst
  task automatic test_no_echo();
    configure(3, 2, 50, 340);
    send_tick(1'b1, 1'b0);
    repeat (30) send_tick(1'($urandom_range(1)), 1'b0);
    settle_to_idle();
  endtask

  task automatic test_backpressure();
    configure(2, 1, 255, 340);
    stall_request = 400;
    run_burst(5, 12, 3);
    run_burst(5, 12, 3);
    drain_results();
    run_burst(1, 10, 3);
  endtask

  task automatic test_random();
    int phase_end;
    for (int p = 0; p < 4; p++) begin
      configure($urandom_range(0, 12),
                ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4),
                ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40),
                $urandom_range(0, 1023));
      gaps_on   = (p != 2);
      phase_end = ticks_sent + 40;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(99) < 80) begin
          run_burst(1, 8, 3);
        end else begin
          repeat ($urandom_range(5, 40))
            send_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
          settle_to_idle();
        end
        if ($urandom_range(19) == 0) drain_results();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_trigger_width();
    test_counter_limits();
    test_no_echo();
    test_backpressure();
    test_random();
    drain_results();
    if (fail_count == 0) begin
      $display("** ultrasonic_echo_ranger: PASSED **");
    end else begin
      $display("** ultrasonic_echo_ranger: FAILED **");
    end
    $finish;
  end

endmodule
